@@ rtl/aicr_pkg.sv @@
// shared types and constants for the arp/icmp reply classifier
package aicr_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQ = 2'd1;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ARP  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_ICMP = 2'd2;

  // frame layout, byte offsets with a 20 byte ip header
  localparam logic [POS_W-1:0] POS_MAX       = 6'd63;
  localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_OPER_HI   = 6'd20;
  localparam logic [POS_W-1:0] POS_OPER_LO   = 6'd21;
  localparam logic [POS_W-1:0] POS_SHA_0     = 6'd22;
  localparam logic [POS_W-1:0] POS_SHA_1     = 6'd23;  // also ip protocol
  localparam logic [POS_W-1:0] POS_SHA_2     = 6'd24;
  localparam logic [POS_W-1:0] POS_SHA_3     = 6'd25;
  localparam logic [POS_W-1:0] POS_SHA_4     = 6'd26;
  localparam logic [POS_W-1:0] POS_SHA_5     = 6'd27;
  localparam logic [POS_W-1:0] POS_SPA_0     = 6'd28;
  localparam logic [POS_W-1:0] POS_SPA_1     = 6'd29;
  localparam logic [POS_W-1:0] POS_SPA_2     = 6'd30;
  localparam logic [POS_W-1:0] POS_SPA_3     = 6'd31;
  localparam logic [POS_W-1:0] POS_ICMP_TYPE = 6'd34;
  localparam logic [POS_W-1:0] POS_SEQ_HI    = 6'd40;
  localparam logic [POS_W-1:0] POS_SEQ_LO    = 6'd41;
  localparam logic [POS_W-1:0] ARP_FRAME_LEN = 6'd42;

  // protocol constants
  localparam logic [15:0]      ETYPE_ARP   = 16'h0806;
  localparam logic [15:0]      ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0]      ARP_OP_REPLY = 16'd2;
  localparam logic [7:0]       IP_PROTO_ICMP = 8'd1;
  localparam logic [7:0]       ICMP_ECHO_REPLY = 8'd0;

  // one frame byte moving from the input register into the parser
  typedef struct packed {
    logic              step;
    logic              last;
    logic [BYTE_W-1:0] data;
  } byte_step_t;

  // classification of a finished frame
  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [MAC_W-1:0]     sender_mac;
  } frame_result_t;

endpackage

@@ rtl/arp_icmp_reply_classifier.sv @@
// top level of the arp reply / icmp echo reply frame classifier
//
//  channel | direction | signals                               | moves
//  in      | sink      | in_valid, in_ready, in_frame_byte,    | one frame byte
//          |           | in_is_last                            |
//  out     | source    | out_valid, out_ready, out_verdict,    | one verdict per frame
//          |           | out_sender_mac                        |
//  cfg     | sink      | cfg_valid, cfg_ready, cfg_index,      | one register write
//          |           | cfg_data                              |
//
// one word per cycle unless a last word waits on a stalled result; a word is held
// in the input register, then the verdict of a last word in the result register.
// synchronous rst_n clears byte count, captured fields, valid and config registers.
// a stalled result only holds back last words; ordinary words keep flowing.
// cfg_ready is always high.
module arp_icmp_reply_classifier
  import aicr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_frame_byte,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VERDICT_W-1:0]  out_verdict,
  output logic [MAC_W-1:0]      out_sender_mac,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 hold_valid_r;
  logic                 hold_last_r;
  logic [BYTE_W-1:0]    hold_byte_r;
  logic [IP_W-1:0]      target_ip_r;
  logic [SEQ_W-1:0]     expected_seq_r;
  logic                 out_valid_r;
  logic [VERDICT_W-1:0] out_verdict_r;
  logic [MAC_W-1:0]     out_sender_mac_r;
  logic                 advance;
  byte_step_t           step;
  frame_result_t        result;

  // the held word moves on unless it is a last word facing a full result
  assign advance  = hold_valid_r && (!hold_last_r || !out_valid_r || out_ready);
  assign in_ready = !hold_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign step.step = advance;
  assign step.last = hold_last_r;
  assign step.data = hold_byte_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_frame_byte;
      hold_last_r <= in_is_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_ip_r    <= '0;
      expected_seq_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_IP:    target_ip_r    <= cfg_data[IP_W-1:0];
        CFG_EXPECTED_SEQ: expected_seq_r <= cfg_data[SEQ_W-1:0];
        default:          ;
      endcase
    end
  end

  aicr_capture u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_i         (step),
    .target_ip_i    (target_ip_r),
    .expected_seq_i (expected_seq_r),
    .result_o       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && hold_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_last_r) begin
      out_verdict_r    <= result.verdict;
      out_sender_mac_r <= result.sender_mac;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_sender_mac = out_sender_mac_r;

endmodule

@@ rtl/aicr_capture.sv @@
// frame byte counter, field capture and verdict logic
module aicr_capture
  import aicr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  byte_step_t           step_i,
  input  logic [IP_W-1:0]      target_ip_i,
  input  logic [SEQ_W-1:0]     expected_seq_i,
  output frame_result_t        result_o
);

  logic [POS_W-1:0]  pos_r,   pos_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic [15:0]       oper_r,  oper_nxt;
  logic [MAC_W-1:0]  mac_r,   mac_nxt;
  logic [IP_W-1:0]   spa_r,   spa_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [7:0]        icmp_r,  icmp_nxt;
  logic [SEQ_W-1:0]  seq_r,   seq_nxt;
  logic              arp_hit;
  logic              icmp_hit;

  // capture the current word at its offset, count until saturation
  always_comb begin
    pos_nxt   = pos_r;
    etype_nxt = etype_r;
    oper_nxt  = oper_r;
    mac_nxt   = mac_r;
    spa_nxt   = spa_r;
    proto_nxt = proto_r;
    icmp_nxt  = icmp_r;
    seq_nxt   = seq_r;
    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
      case (pos_r)
        POS_ETYPE_HI:  etype_nxt[15:8] = step_i.data;
        POS_ETYPE_LO:  etype_nxt[7:0]  = step_i.data;
        POS_OPER_HI:   oper_nxt[15:8]  = step_i.data;
        POS_OPER_LO:   oper_nxt[7:0]   = step_i.data;
        POS_SHA_0:     mac_nxt[7:0]    = step_i.data;
        POS_SHA_1: begin
          mac_nxt[15:8] = step_i.data;
          proto_nxt     = step_i.data;
        end
        POS_SHA_2:     mac_nxt[23:16]  = step_i.data;
        POS_SHA_3:     mac_nxt[31:24]  = step_i.data;
        POS_SHA_4:     mac_nxt[39:32]  = step_i.data;
        POS_SHA_5:     mac_nxt[47:40]  = step_i.data;
        POS_SPA_0:     spa_nxt[7:0]    = step_i.data;
        POS_SPA_1:     spa_nxt[15:8]   = step_i.data;
        POS_SPA_2:     spa_nxt[23:16]  = step_i.data;
        POS_SPA_3:     spa_nxt[31:24]  = step_i.data;
        POS_ICMP_TYPE: icmp_nxt        = step_i.data;
        POS_SEQ_HI:    seq_nxt[15:8]   = step_i.data;
        POS_SEQ_LO:    seq_nxt[7:0]    = step_i.data;
        default:       ;
      endcase
    end
  end

  // verdict on the fields including the current word
  assign arp_hit  = (pos_nxt >= ARP_FRAME_LEN) && (etype_nxt == ETYPE_ARP) &&
                    (oper_nxt == ARP_OP_REPLY) && (spa_nxt == target_ip_i);
  assign icmp_hit = (pos_nxt > ARP_FRAME_LEN) && (etype_nxt == ETYPE_IPV4) &&
                    (proto_nxt == IP_PROTO_ICMP) && (icmp_nxt == ICMP_ECHO_REPLY) &&
                    (seq_nxt == expected_seq_i);

  always_comb begin
    result_o.verdict    = VERDICT_NONE;
    result_o.sender_mac = '0;
    if (arp_hit) begin
      result_o.verdict    = VERDICT_ARP;
      result_o.sender_mac = mac_nxt;
    end else if (icmp_hit) begin
      result_o.verdict = VERDICT_ICMP;
    end
  end

  // frame state, cleared after the last word
  always_ff @(posedge clk) begin
    if (!rst_n || (step_i.step && step_i.last)) begin
      pos_r   <= '0;
      etype_r <= '0;
      oper_r  <= '0;
      mac_r   <= '0;
      spa_r   <= '0;
      proto_r <= '0;
      icmp_r  <= '0;
      seq_r   <= '0;
    end else if (step_i.step) begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      oper_r  <= oper_nxt;
      mac_r   <= mac_nxt;
      spa_r   <= spa_nxt;
      proto_r <= proto_nxt;
      icmp_r  <= icmp_nxt;
      seq_r   <= seq_nxt;
    end
  end

endmodule
